>>> rtl/sphdp_pkg.sv
// Shared types, register indexes and constants for the SPH density/pressure block.
package sphdp_pkg;

   // Position field width default (signed Q1.14 at 16 bits)
   localparam int POSITION_WIDTH_DEF = 16;
   // Depth of the queue between front and back; a power of two
   localparam int QUEUE_DEPTH_DEF    = 4;

   // r2 bits that matter: h2 never reaches 2^30
   localparam int R2_W      = 30;
   localparam int RADIUS_W  = 15;
   localparam int WORD_W    = 32;
   localparam int CSR_IDX_W = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING_RADIUS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INV_H_SQUARED    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POLY6_SCALE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STIFFNESS        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_DENSITY   = 3'd4;

   // Register reset values
   localparam logic [RADIUS_W-1:0] RADIUS_RESET         = 15'd1638;
   localparam logic [WORD_W-1:0]   INV_H_SQUARED_RESET  = 32'd6553600;
   localparam logic [WORD_W-1:0]   POLY6_SCALE_RESET    = 32'd102624000;
   localparam logic [WORD_W-1:0]   STIFFNESS_RESET      = 32'd65536;
   localparam logic [WORD_W-1:0]   TARGET_DENSITY_RESET = 32'd76972032;
   localparam logic [R2_W-1:0]     H2_RESET             = R2_W'(1638 * 1638);

   // Kernel constants (Q.16)
   localparam logic [16:0] KERNEL_ONE = 17'h10000;

   // Saturation limits
   localparam logic [WORD_W-1:0] DENSITY_MAX  = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] PRESSURE_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] PRESSURE_MIN = 32'h8000_0000;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [R2_W-1:0]   h2;
      logic [WORD_W-1:0] inv_h_squared;
      logic [WORD_W-1:0] poly6_scale;
      logic [WORD_W-1:0] stiffness;
      logic [WORD_W-1:0] target_density;
   } sphdp_cfg_type;

   // One classified neighbor in the queue
   typedef struct packed {
      logic [R2_W-1:0] r2;
      logic            in_kernel;
      logic            last;
   } sphdp_entry_type;

endpackage

>>> rtl/sphdp_req_if.sv
// Request channel: particle and neighbor positions plus last-neighbor flag.
interface sphdp_req_if #(
   parameter int POSITION_WIDTH = sphdp_pkg::POSITION_WIDTH_DEF
);
   logic                             valid;
   logic                             ready;
   logic signed [POSITION_WIDTH-1:0] center_x;
   logic signed [POSITION_WIDTH-1:0] center_y;
   logic signed [POSITION_WIDTH-1:0] center_z;
   logic signed [POSITION_WIDTH-1:0] neighbor_x;
   logic signed [POSITION_WIDTH-1:0] neighbor_y;
   logic signed [POSITION_WIDTH-1:0] neighbor_z;
   logic                             last_neighbor;

   modport source (
      output valid, center_x, center_y, center_z,
      output neighbor_x, neighbor_y, neighbor_z, last_neighbor,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, center_z,
      input  neighbor_x, neighbor_y, neighbor_z, last_neighbor,
      output ready
   );
endinterface

>>> rtl/sphdp_rsp_if.sv
// Response channel: density and pressure of one particle.
interface sphdp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [sphdp_pkg::WORD_W-1:0]   density;
   logic signed [sphdp_pkg::WORD_W-1:0]   pressure;

   modport source (output valid, density, pressure, input ready);
   modport sink   (input valid, density, pressure, output ready);
endinterface

>>> rtl/sphdp_csr_if.sv
// Configuration write channel: register index and write data.
interface sphdp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sphdp_pkg::CSR_IDX_W-1:0]   index;
   logic [sphdp_pkg::WORD_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/sphdp_front.sv
// Front end: axis differences, squares, r2 sum and kernel-radius classification.
module sphdp_front #(
   parameter int POSITION_WIDTH = sphdp_pkg::POSITION_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   sphdp_req_if.sink                      req_chan,
   input  logic [sphdp_pkg::R2_W-1:0]     h2,
   input  logic                           q_full,
   output logic                           q_push,
   output sphdp_pkg::sphdp_entry_type     q_entry
);
   localparam int DIFF_W  = POSITION_WIDTH + 1;
   localparam int SQ_W    = 2 * POSITION_WIDTH + 1;
   localparam int SUM_RAW = 2 * POSITION_WIDTH + 3;
   localparam int SUM_W   = (SUM_RAW > sphdp_pkg::R2_W) ? SUM_RAW : sphdp_pkg::R2_W;

   logic                     advance;
   logic signed [DIFF_W-1:0] dx_in, dy_in, dz_in;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic                     s1_valid_ff, s1_last_ff;
   logic signed [2*DIFF_W-1:0] px, py, pz;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff, sqz_ff;
   logic                     s2_valid_ff, s2_last_ff;
   logic [SUM_W-1:0]         r2_sum;

   assign advance        = !s2_valid_ff || !q_full;
   assign req_chan.ready = advance;

   assign dx_in = $signed({req_chan.center_x[POSITION_WIDTH-1], req_chan.center_x})
                - $signed({req_chan.neighbor_x[POSITION_WIDTH-1], req_chan.neighbor_x});
   assign dy_in = $signed({req_chan.center_y[POSITION_WIDTH-1], req_chan.center_y})
                - $signed({req_chan.neighbor_y[POSITION_WIDTH-1], req_chan.neighbor_y});
   assign dz_in = $signed({req_chan.center_z[POSITION_WIDTH-1], req_chan.center_z})
                - $signed({req_chan.neighbor_z[POSITION_WIDTH-1], req_chan.neighbor_z});

   assign px = (2*DIFF_W)'(dx_ff) * (2*DIFF_W)'(dx_ff);
   assign py = (2*DIFF_W)'(dy_ff) * (2*DIFF_W)'(dy_ff);
   assign pz = (2*DIFF_W)'(dz_ff) * (2*DIFF_W)'(dz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         dz_ff      <= dz_in;
         s1_last_ff <= req_chan.last_neighbor;
         // a square of a signed value is never negative
         sqx_ff     <= px[SQ_W-1:0];
         sqy_ff     <= py[SQ_W-1:0];
         sqz_ff     <= pz[SQ_W-1:0];
         s2_last_ff <= s1_last_ff;
      end
   end

   // three squares of at most 2^(2P) each cannot overflow SUM_W
   assign r2_sum = SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);

   assign q_push            = s2_valid_ff && !q_full;
   assign q_entry.r2        = r2_sum[sphdp_pkg::R2_W-1:0];
   assign q_entry.in_kernel = r2_sum < SUM_W'(h2);
   assign q_entry.last      = s2_last_ff;

endmodule

>>> rtl/sphdp_fifo.sv
// Short queue of classified neighbors between front and back.
module sphdp_fifo #(
   parameter int DEPTH = sphdp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sphdp_pkg::sphdp_entry_type  push_entry,
   input  logic                        pop,
   output sphdp_pkg::sphdp_entry_type  head_entry,
   output logic                        full,
   output logic                        not_empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sphdp_pkg::sphdp_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign not_empty  = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

>>> rtl/sphdp_back.sv
// Back end: poly6 kernel pipeline, saturating density sum and pressure stage.
module sphdp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  sphdp_pkg::sphdp_cfg_type    cfg,
   input  sphdp_pkg::sphdp_entry_type  q_entry,
   input  logic                        q_valid,
   output logic                        q_pop,
   sphdp_rsp_if.source                 rsp_chan
);
   localparam int W = sphdp_pkg::WORD_W;

   logic                         adv;
   // kernel stages
   logic                         k1_valid_ff, k1_in_ff, k1_last_ff;
   logic [sphdp_pkg::R2_W+W-1:0] k1_prod_ff;
   logic [33:0]                  q_val;
   logic                         kill;
   logic [16:0]                  t_in;
   logic                         k2_valid_ff, k2_last_ff;
   logic [16:0]                  k2_t_ff;
   logic [33:0]                  k2_tsq_ff;
   logic                         k3_valid_ff, k3_last_ff;
   logic [33:0]                  k3_tcube_ff;
   logic                         k4_valid_ff, k4_last_ff;
   logic [W+16:0]                k4_wprod_ff;
   // accumulation
   logic [W-1:0]                 weight;
   logic [W:0]                   sum_wide;
   logic [W-1:0]                 sum_in, sum_ff;
   logic                         acc_valid_ff;
   logic [W-1:0]                 acc_density_ff;
   // pressure stages
   logic                         p1_valid_ff, p1_neg_ff;
   logic [W-1:0]                 p1_mag_ff, p1_density_ff;
   logic                         p2_valid_ff, p2_neg_ff;
   logic [2*W-1:0]               p2_prod_ff;
   logic [W-1:0]                 p2_density_ff;
   logic [47:0]                  p_mag;
   logic [W-1:0]                 pressure_in;
   // output register
   logic                         rsp_valid_ff;
   logic [W-1:0]                 density_ff, pressure_ff;

   assign adv   = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop = adv && q_valid;

   // q = r2 * inv_h^2 >> 28; outside the kernel or q >= 1 gives zero weight
   assign q_val  = k1_prod_ff[sphdp_pkg::R2_W+W-1:28];
   assign kill   = !k1_in_ff || (q_val[33:16] != '0);
   assign t_in   = kill ? 17'd0 : (sphdp_pkg::KERNEL_ONE - {1'b0, q_val[15:0]});

   assign weight   = k4_wprod_ff[W+15:16];
   assign sum_wide = {1'b0, sum_ff} + {1'b0, weight};
   assign sum_in   = sum_wide[W] ? sphdp_pkg::DENSITY_MAX : sum_wide[W-1:0];

   assign p_mag = p2_prod_ff[63:16];
   always_comb begin
      if (p2_neg_ff) begin
         if (p_mag[47:31] != '0) pressure_in = sphdp_pkg::PRESSURE_MIN;
         else                    pressure_in = W'(0) - p_mag[W-1:0];
      end else begin
         if (p_mag[47:31] != '0) pressure_in = sphdp_pkg::PRESSURE_MAX;
         else                    pressure_in = p_mag[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_valid_ff  <= 1'b0;
         k2_valid_ff  <= 1'b0;
         k3_valid_ff  <= 1'b0;
         k4_valid_ff  <= 1'b0;
         acc_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else if (adv) begin
         k1_valid_ff  <= q_valid;
         k2_valid_ff  <= k1_valid_ff;
         k3_valid_ff  <= k2_valid_ff;
         k4_valid_ff  <= k3_valid_ff;
         // only a last neighbor travels on into the pressure stages
         acc_valid_ff <= k4_valid_ff && k4_last_ff;
         p1_valid_ff  <= acc_valid_ff;
         p2_valid_ff  <= p1_valid_ff;
         rsp_valid_ff <= p2_valid_ff;
         if (k4_valid_ff) begin
            sum_ff <= k4_last_ff ? '0 : sum_in;
         end
      end
      if (adv) begin
         k1_prod_ff     <= (sphdp_pkg::R2_W+W)'(q_entry.r2)
                         * (sphdp_pkg::R2_W+W)'(cfg.inv_h_squared);
         k1_in_ff       <= q_entry.in_kernel;
         k1_last_ff     <= q_entry.last;
         k2_t_ff        <= t_in;
         k2_tsq_ff      <= 34'(t_in) * 34'(t_in);
         k2_last_ff     <= k1_last_ff;
         k3_tcube_ff    <= 34'(k2_tsq_ff[32:16]) * 34'(k2_t_ff);
         k3_last_ff     <= k2_last_ff;
         k4_wprod_ff    <= (W+17)'(cfg.poly6_scale) * (W+17)'(k3_tcube_ff[32:16]);
         k4_last_ff     <= k3_last_ff;
         acc_density_ff <= sum_in;
         p1_neg_ff      <= acc_density_ff < cfg.target_density;
         p1_mag_ff      <= (acc_density_ff < cfg.target_density)
                         ? cfg.target_density - acc_density_ff
                         : acc_density_ff - cfg.target_density;
         p1_density_ff  <= acc_density_ff;
         p2_prod_ff     <= (2*W)'(p1_mag_ff) * (2*W)'(cfg.stiffness);
         p2_neg_ff      <= p1_neg_ff;
         p2_density_ff  <= p1_density_ff;
         density_ff     <= p2_density_ff;
         pressure_ff    <= pressure_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.density  = density_ff;
   assign rsp_chan.pressure = pressure_ff;

endmodule

>>> rtl/sph_density_pressure_accumulator_top.sv
// A last neighbor goes through front, queue, kernel, sum, pressure and output registers.
// Throughput: one neighbor per cycle while the response is accepted; the kernel pipeline
// issues every unheld cycle and only the saturating density add feeds back on itself.
// A stalled response holds the back pipeline; the 4-entry queue absorbs front traffic.
// Reset (synchronous) empties the pipelines and queue, clears the density sum and
// loads every configuration register with its default.
module sph_density_pressure_accumulator_top #(
   parameter int POSITION_WIDTH = sphdp_pkg::POSITION_WIDTH_DEF,
   parameter int QUEUE_DEPTH    = sphdp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   sphdp_req_if.sink    req_chan,
   sphdp_rsp_if.source  rsp_chan,
   sphdp_csr_if.sink    csr_chan
);
   logic [sphdp_pkg::RADIUS_W-1:0] radius_ff;
   logic [sphdp_pkg::R2_W-1:0]     h2_ff;
   logic [sphdp_pkg::WORD_W-1:0]   inv_h_ff, poly6_ff, stiffness_ff, rest_ff;
   sphdp_pkg::sphdp_cfg_type       cfg;
   sphdp_pkg::sphdp_entry_type     push_entry, head_entry;
   logic                           q_push, q_pop, q_full, q_not_empty;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= sphdp_pkg::RADIUS_RESET;
         h2_ff        <= sphdp_pkg::H2_RESET;
         inv_h_ff     <= sphdp_pkg::INV_H_SQUARED_RESET;
         poly6_ff     <= sphdp_pkg::POLY6_SCALE_RESET;
         stiffness_ff <= sphdp_pkg::STIFFNESS_RESET;
         rest_ff      <= sphdp_pkg::TARGET_DENSITY_RESET;
      end else begin
         // h squared is registered from the radius and follows it in the next cycle
         h2_ff <= (sphdp_pkg::R2_W)'(radius_ff) * (sphdp_pkg::R2_W)'(radius_ff);
         if (csr_chan.valid) begin
            case (csr_chan.index)
               sphdp_pkg::REG_SMOOTHING_RADIUS:
                  radius_ff <= csr_chan.data[sphdp_pkg::RADIUS_W-1:0];
               sphdp_pkg::REG_INV_H_SQUARED:  inv_h_ff     <= csr_chan.data;
               sphdp_pkg::REG_POLY6_SCALE:    poly6_ff     <= csr_chan.data;
               sphdp_pkg::REG_STIFFNESS:      stiffness_ff <= csr_chan.data;
               sphdp_pkg::REG_TARGET_DENSITY: rest_ff      <= csr_chan.data;
               default: ;
            endcase
         end
      end
   end

   assign cfg.h2             = h2_ff;
   assign cfg.inv_h_squared  = inv_h_ff;
   assign cfg.poly6_scale    = poly6_ff;
   assign cfg.stiffness      = stiffness_ff;
   assign cfg.target_density = rest_ff;

   sphdp_front #(.POSITION_WIDTH(POSITION_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .h2       (cfg.h2),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (push_entry)
   );

   sphdp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .not_empty  (q_not_empty)
   );

   sphdp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_entry  (head_entry),
      .q_valid  (q_not_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/sphdp_checker.sv
// Port-level checks on the SPH density/pressure block, bound to its top level.
module sphdp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sphdp_pkg::WORD_W-1:0]  density,
   input logic [sphdp_pkg::WORD_W-1:0]  pressure
);
   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(density) && $stable(pressure))
      else $error("response payload changed while stalled");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

   // zero density can never give positive pressure
   a_zero_density: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && density == '0 |-> pressure[sphdp_pkg::WORD_W-1] || pressure == '0)
      else $error("positive pressure with zero density");

endmodule

bind sph_density_pressure_accumulator_top sphdp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .density   (rsp_chan.density),
   .pressure  (rsp_chan.pressure)
);

>>> dv/sph_density_pressure_accumulator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SPH density/pressure block.
module sph_density_pressure_accumulator_top_tb;

   localparam int POS_W        = sphdp_pkg::POSITION_WIDTH_DEF;
   localparam int WORD_W       = sphdp_pkg::WORD_W;
   localparam int RADIUS_W     = sphdp_pkg::RADIUS_W;
   localparam int CSR_IDX_W    = sphdp_pkg::CSR_IDX_W;
   localparam int PHASE_ITEMS  = 250;
   localparam int RANDOM_ITEMS = 1750;
   localparam int STALL_ITEMS  = 60;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int BUSY_PCT     = 32;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RADIUS_TOP   = 16384;

   // Indexes past the last register: writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct packed {
      pos_type center_x;
      pos_type center_y;
      pos_type center_z;
      pos_type neighbor_x;
      pos_type neighbor_y;
      pos_type neighbor_z;
      logic    last_neighbor;
   } neighbor_type;

   typedef struct packed {
      logic [WORD_W-1:0] density;
      logic [WORD_W-1:0] pressure;
   } particle_result_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [WORD_W-1:0]    data;
   } reg_write_type;

   logic clock;
   logic reset;

   sphdp_req_if #(.POSITION_WIDTH(POS_W)) req_bus ();
   sphdp_rsp_if rsp_bus ();
   sphdp_csr_if csr_bus ();

   sph_density_pressure_accumulator_top #(.POSITION_WIDTH(POS_W)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor copy of the registers and the running sum
   logic [RADIUS_W-1:0] model_radius;
   logic [WORD_W-1:0]   model_inv_h2;
   logic [WORD_W-1:0]   model_poly6;
   logic [WORD_W-1:0]   model_stiffness;
   logic [WORD_W-1:0]   model_rest;
   logic [WORD_W-1:0]   density_acc;

   particle_result_type particle_result_q[$];
   reg_write_type       csr_write_q[$];

   logic [RADIUS_W-1:0] stim_radius = sphdp_pkg::RADIUS_RESET;
   int fail_count  = 0;
   int idle_pct    = BUSY_PCT;
   int hold_req    = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] axis_dist2(input pos_type a, input pos_type b);
      logic signed [POS_W:0] diff;
      logic [POS_W:0]        mag;
      diff = a - b;
      mag  = (diff < 0) ? -diff : diff;
      return 64'(mag) * 64'(mag);
   endfunction

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [WORD_W-1:0] kernel_weight(input logic [63:0] r2);
      logic [63:0] h2;
      logic [63:0] q;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] t3;
      h2 = 64'(model_radius) * 64'(model_radius);
      if (r2 >= h2) return '0;
      q = (r2 * 64'(model_inv_h2)) >> 28;
      // inv_h_squared too large for this radius: no contribution
      if (q >= 64'(sphdp_pkg::KERNEL_ONE)) return '0;
      t  = 64'(sphdp_pkg::KERNEL_ONE) - q;
      t2 = (t * t) >> 16;
      t3 = (t2 * t) >> 16;
      return WORD_W'((64'(model_poly6) * t3) >> 16);
   endfunction

   function automatic logic [WORD_W-1:0] excess_pressure(input logic [WORD_W-1:0] d);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] p;
      neg = d < model_rest;
      mag = neg ? 64'(model_rest - d) : 64'(d - model_rest);
      p   = (mag * 64'(model_stiffness)) >> 16;
      if (neg) begin
         return (p >= 64'(sphdp_pkg::PRESSURE_MIN)) ? sphdp_pkg::PRESSURE_MIN : WORD_W'(-p);
      end
      return (p > 64'(sphdp_pkg::PRESSURE_MAX)) ? sphdp_pkg::PRESSURE_MAX : p[WORD_W-1:0];
   endfunction

   function automatic void accumulate_neighbor(input neighbor_type nb);
      logic [63:0]         r2;
      logic [WORD_W:0]     sum;
      particle_result_type res;
      r2  = sat_add64(axis_dist2(nb.center_x, nb.neighbor_x),
                      axis_dist2(nb.center_y, nb.neighbor_y));
      r2  = sat_add64(r2, axis_dist2(nb.center_z, nb.neighbor_z));
      sum = {1'b0, density_acc} + {1'b0, kernel_weight(r2)};
      density_acc = sum[WORD_W] ? sphdp_pkg::DENSITY_MAX : sum[WORD_W-1:0];
      if (nb.last_neighbor) begin
         res.density  = density_acc;
         res.pressure = excess_pressure(density_acc);
         particle_result_q.push_back(res);
         density_acc = '0;
      end
   endfunction

   // Track register writes and accepted neighbors
   always @(posedge clock) begin
      neighbor_type nb;
      if (reset) begin
         model_radius    = sphdp_pkg::RADIUS_RESET;
         model_inv_h2    = sphdp_pkg::INV_H_SQUARED_RESET;
         model_poly6     = sphdp_pkg::POLY6_SCALE_RESET;
         model_stiffness = sphdp_pkg::STIFFNESS_RESET;
         model_rest      = sphdp_pkg::TARGET_DENSITY_RESET;
         density_acc     = '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               sphdp_pkg::REG_SMOOTHING_RADIUS: model_radius = csr_bus.data[RADIUS_W-1:0];
               sphdp_pkg::REG_INV_H_SQUARED:    model_inv_h2    = csr_bus.data;
               sphdp_pkg::REG_POLY6_SCALE:      model_poly6     = csr_bus.data;
               sphdp_pkg::REG_STIFFNESS:        model_stiffness = csr_bus.data;
               sphdp_pkg::REG_TARGET_DENSITY:   model_rest      = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            nb.center_x      = req_bus.center_x;
            nb.center_y      = req_bus.center_y;
            nb.center_z      = req_bus.center_z;
            nb.neighbor_x    = req_bus.neighbor_x;
            nb.neighbor_y    = req_bus.neighbor_y;
            nb.neighbor_z    = req_bus.neighbor_z;
            nb.last_neighbor = req_bus.last_neighbor;
            accumulate_neighbor(nb);
         end
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      particle_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (particle_result_q.size() == 0) begin
            $error("unexpected result: density %0d pressure %0d",
                   rsp_bus.density, $signed(rsp_bus.pressure));
            fail_count++;
         end else begin
            want = particle_result_q.pop_front();
            if (rsp_bus.density !== want.density) begin
               $error("density: expected %0d, actual %0d", want.density, rsp_bus.density);
               fail_count++;
            end
            if (rsp_bus.pressure !== want.pressure) begin
               $error("pressure: expected %0d, actual %0d",
                      $signed(want.pressure), $signed(rsp_bus.pressure));
               fail_count++;
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold-off on request
   initial begin
      int stall_len;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != 0) begin
            stall_len = hold_req;
            hold_req  = 0;
            rsp_bus.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sph_density_pressure_accumulator_top regression: fail");
         $finish;
      end
   end

   function automatic neighbor_type mk_neighbor(input pos_type cx, input pos_type cy,
                                                input pos_type cz, input pos_type nx,
                                                input pos_type ny, input pos_type nz,
                                                input logic last);
      neighbor_type nb;
      nb.center_x      = cx;
      nb.center_y      = cy;
      nb.center_z      = cz;
      nb.neighbor_x    = nx;
      nb.neighbor_y    = ny;
      nb.neighbor_z    = nz;
      nb.last_neighbor = last;
      return nb;
   endfunction

   function automatic pos_type near_pos(input pos_type c, input int span);
      int off;
      off = int'($urandom_range(2 * span)) - span;
      return pos_type'(int'(c) + off);
   endfunction

   task automatic send_neighbor(input neighbor_type nb);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.center_x      <= nb.center_x;
      req_bus.center_y      <= nb.center_y;
      req_bus.center_z      <= nb.center_z;
      req_bus.neighbor_x    <= nb.neighbor_x;
      req_bus.neighbor_y    <= nb.neighbor_y;
      req_bus.neighbor_z    <= nb.neighbor_z;
      req_bus.last_neighbor <= nb.last_neighbor;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid, wait for all predicted results, then let the pipeline drain
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (particle_result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs();
      reg_write_type wr;
      while (csr_write_q.size() != 0) begin
         wr = csr_write_q.pop_front();
         csr_bus.valid <= 1'b1;
         csr_bus.index <= wr.index;
         csr_bus.data  <= wr.data;
         if (wr.index == sphdp_pkg::REG_SMOOTHING_RADIUS) begin
            stim_radius = wr.data[RADIUS_W-1:0];
         end
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_regs(input logic [WORD_W-1:0] radius, input logic [WORD_W-1:0] inv_h2,
                           input logic [WORD_W-1:0] poly6, input logic [WORD_W-1:0] stiff,
                           input logic [WORD_W-1:0] rest);
      csr_write_q.push_back('{sphdp_pkg::REG_SMOOTHING_RADIUS, radius});
      csr_write_q.push_back('{sphdp_pkg::REG_INV_H_SQUARED, inv_h2});
      csr_write_q.push_back('{sphdp_pkg::REG_POLY6_SCALE, poly6});
      csr_write_q.push_back('{sphdp_pkg::REG_STIFFNESS, stiff});
      csr_write_q.push_back('{sphdp_pkg::REG_TARGET_DENSITY, rest});
      program_regs();
   endtask

   task automatic set_default_regs();
      set_regs(32'(sphdp_pkg::RADIUS_RESET), sphdp_pkg::INV_H_SQUARED_RESET,
               sphdp_pkg::POLY6_SCALE_RESET, sphdp_pkg::STIFFNESS_RESET,
               sphdp_pkg::TARGET_DENSITY_RESET);
   endtask

   task automatic test_directed_kernel();
      // self only, then far corners, then a short particle
      send_neighbor(mk_neighbor(0, 0, 0, 0, 0, 0, 1'b1));
      send_neighbor(mk_neighbor(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0));
      send_neighbor(mk_neighbor(1000, -2000, 300, 1100, -2200, 350, 1'b0));
      send_neighbor(mk_neighbor(1000, -2000, 300, 1000, -2000, 300, 1'b1));
      // exactly on the radius is outside, one step in is inside
      send_neighbor(mk_neighbor(500, 500, 500, 500 + 1638, 500, 500, 1'b0));
      send_neighbor(mk_neighbor(500, 500, 500, 500, 500 - 1637, 500, 1'b1));
      send_neighbor(mk_neighbor(32767, 32767, 32767, 32767, 32767, 32767, 1'b1));
      send_neighbor(mk_neighbor(-32768, 0, 32767, -31768, 0, 32767, 1'b1));
      settle();
   endtask

   task automatic test_register_extremes();
      // zero radius: nothing contributes, pressure is minus rest density
      set_regs(32'd0, sphdp_pkg::INV_H_SQUARED_RESET, sphdp_pkg::POLY6_SCALE_RESET,
               sphdp_pkg::STIFFNESS_RESET, sphdp_pkg::TARGET_DENSITY_RESET);
      send_neighbor(mk_neighbor(0, 0, 0, 0, 0, 0, 1'b1));
      settle();
      // full-scale weights: density and pressure saturate high; upper radius bits ignored
      set_regs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_neighbor(mk_neighbor(0, 0, 0, 0, 0, 0, 1'b0));
      send_neighbor(mk_neighbor(0, 0, 0, 20000, 0, 0, 1'b0));
      send_neighbor(mk_neighbor(0, 0, 0, 0, -20000, 0, 1'b0));
      send_neighbor(mk_neighbor(-5, 7, 9, -5, 7, 9, 1'b1));
      settle();
      // empty particle far below rest: pressure saturates low
      set_regs(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_neighbor(mk_neighbor(100, 200, 300, 100, 200, 300, 1'b1));
      settle();
      // oversized inv_h_squared rejects an inside point; zero gain gives zero pressure
      set_regs(32'(RADIUS_TOP), 32'hFFFF_FFFF, sphdp_pkg::POLY6_SCALE_RESET, 32'd0,
               sphdp_pkg::TARGET_DENSITY_RESET);
      send_neighbor(mk_neighbor(0, 0, 0, 10000, 0, 0, 1'b0));
      send_neighbor(mk_neighbor(0, 0, 0, 0, 0, 0, 1'b1));
      settle();
      set_default_regs();
      for (int idx = REG_UNMAPPED_LO; idx <= REG_UNMAPPED_HI; idx++) begin
         csr_write_q.push_back('{CSR_IDX_W'(idx), $urandom});
      end
      program_regs();
      send_neighbor(mk_neighbor(0, 0, 0, 300, 300, 300, 1'b0));
      send_neighbor(mk_neighbor(0, 0, 0, 0, 0, 0, 1'b1));
      settle();
   endtask

   task automatic test_stalled_results();
      pos_type cx;
      pos_type cy;
      pos_type cz;
      idle_pct = 0;
      hold_req = HOLD_CYCLES;
      // keep offering one-neighbor particles while results are held off
      for (int i = 0; i < STALL_ITEMS; i++) begin
         cx = pos_type'($urandom);
         cy = pos_type'($urandom);
         cz = pos_type'($urandom);
         send_neighbor(mk_neighbor(cx, cy, cz, near_pos(cx, 1000), near_pos(cy, 1000),
                                   near_pos(cz, 1000), 1'b1));
      end
      settle();
      idle_pct = BUSY_PCT;
   endtask

   task automatic randomize_regs();
      logic [63:0] base;
      logic [63:0] inv;
      int          r;
      if ($urandom_range(3) == 0) begin
         set_regs($urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         r    = $urandom_range(RADIUS_TOP, 1);
         base = (64'd1 << 44) / (64'(r) * 64'(r));
         if (base > 64'hFFFF_FFFF) base = 64'hFFFF_FFFF;
         // jitter around 1/h^2 so points near the rim land on both sides
         inv = base - base / 64 + 64'($urandom_range(32'(base / 32)));
         if (inv > 64'hFFFF_FFFF) inv = 64'hFFFF_FFFF;
         set_regs(32'(r), inv[WORD_W-1:0],
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0800_0000),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000),
                  ($urandom_range(1) == 0) ? $urandom : $urandom_range(32'h1000_0000));
      end
   endtask

   task automatic test_random_particles();
      neighbor_type nb;
      int           sent;
      int           n_nb;
      int           kind;
      int           span;
      for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
         randomize_regs();
         idle_pct = (phase == 1) ? 0 : BUSY_PCT;
         span     = int'(stim_radius) + int'(stim_radius) / 8;
         sent     = 0;
         while (sent < PHASE_ITEMS) begin
            nb.center_x = pos_type'($urandom);
            nb.center_y = pos_type'($urandom);
            nb.center_z = pos_type'($urandom);
            n_nb = $urandom_range(12, 1);
            for (int k = 0; k < n_nb; k++) begin
               kind = $urandom_range(19);
               if (kind == 0) begin
                  nb.neighbor_x = pos_type'($urandom);
                  nb.neighbor_y = pos_type'($urandom);
                  nb.neighbor_z = pos_type'($urandom);
               end else if (kind == 1) begin
                  nb.neighbor_x = nb.center_x;
                  nb.neighbor_y = nb.center_y;
                  nb.neighbor_z = nb.center_z;
               end else begin
                  nb.neighbor_x = near_pos(nb.center_x, span);
                  nb.neighbor_y = near_pos(nb.center_y, span);
                  nb.neighbor_z = near_pos(nb.center_z, span);
               end
               // occasionally drop the closing flag so particles run together
               nb.last_neighbor = (k == n_nb - 1) && ($urandom_range(19) != 0);
               send_neighbor(nb);
               sent++;
            end
         end
         settle();
      end
      idle_pct = BUSY_PCT;
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.center_x      <= '0;
      req_bus.center_y      <= '0;
      req_bus.center_z      <= '0;
      req_bus.neighbor_x    <= '0;
      req_bus.neighbor_y    <= '0;
      req_bus.neighbor_z    <= '0;
      req_bus.last_neighbor <= 1'b0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= '0;
      csr_bus.data          <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_kernel();
      test_register_extremes();
      test_stalled_results();
      test_random_particles();

      if (particle_result_q.size() != 0) begin
         $error("%0d predicted results never arrived", particle_result_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("sph_density_pressure_accumulator_top regression: pass");
      end else begin
         $display("sph_density_pressure_accumulator_top regression: fail");
      end
      $finish;
   end

endmodule

>>> sph_density_pressure_accumulator_top.f
rtl/sphdp_pkg.sv
rtl/sphdp_req_if.sv
rtl/sphdp_rsp_if.sv
rtl/sphdp_csr_if.sv
rtl/sphdp_front.sv
rtl/sphdp_fifo.sv
rtl/sphdp_back.sv
rtl/sph_density_pressure_accumulator_top.sv
rtl/sphdp_checker.sv
dv/sph_density_pressure_accumulator_top_tb.sv
